>>> src/cpualu_pkg.sv
`default_nettype none

package cpualu_pkg;

    // Operation codes carried on the command field.
    typedef enum logic [4:0] {
        CMD_ADD    = 5'd0,
        CMD_ADC    = 5'd1,
        CMD_SUB    = 5'd2,
        CMD_SBC    = 5'd3,
        CMD_AND    = 5'd4,
        CMD_OR     = 5'd5,
        CMD_XOR    = 5'd6,
        CMD_INC    = 5'd7,
        CMD_DEC    = 5'd8,
        CMD_RLC    = 5'd9,
        CMD_RL     = 5'd10,
        CMD_RRC    = 5'd11,
        CMD_RR     = 5'd12,
        CMD_SLA    = 5'd13,
        CMD_SRA    = 5'd14,
        CMD_SRL    = 5'd15,
        CMD_SWAP   = 5'd16,
        CMD_BIT    = 5'd17,
        CMD_SET    = 5'd18,
        CMD_RES    = 5'd19,
        CMD_ADD16  = 5'd20,
        CMD_ADDOFS = 5'd21
    } t_cmd;

    // Flag word layout.
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } t_flags;

    // One operation beat as it travels from the input register to the ALU.
    typedef struct packed {
        t_cmd        cmd;
        logic [15:0] a;
        logic [15:0] b;
        logic [2:0]  idx;
        t_flags      flags;
    } t_alu_req;

endpackage

`default_nettype wire

>>> src/cpualu_core.sv
`default_nettype none

module cpualu_core (
    input  cpualu_pkg::t_alu_req i_req,
    output logic [15:0]          o_result,
    output cpualu_pkg::t_flags   o_flags
);
    import cpualu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic        use_c;
    logic        tc;
    logic [8:0]  sum8;
    logic [4:0]  sum4;
    logic [8:0]  dif8;
    logic [4:0]  dif4;
    logic [7:0]  mask;
    logic [16:0] sum16;
    logic [12:0] sum12;
    logic [15:0] ofs;
    logic [7:0]  r8;
    logic        z8;

    // Shared adders for the 8-bit and 16-bit arithmetic.
    always_comb begin
        a     = i_req.a[7:0];
        b     = i_req.b[7:0];
        cin   = i_req.flags.c;
        use_c = (i_req.cmd == CMD_ADC) || (i_req.cmd == CMD_SBC);
        tc    = use_c & cin;
        sum8  = {1'b0, a} + {1'b0, b} + {8'd0, tc};
        sum4  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, tc};
        dif8  = {1'b0, a} - {1'b0, b} - {8'd0, tc};
        dif4  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, tc};
        mask  = 8'd1 << i_req.idx;
        sum16 = {1'b0, i_req.a} + {1'b0, i_req.b};
        sum12 = {1'b0, i_req.a[11:0]} + {1'b0, i_req.b[11:0]};
        ofs   = i_req.a + {{8{b[7]}}, b};
    end

    // Result and flag selection by operation.
    always_comb begin
        r8       = 8'd0;
        o_result = 16'd0;
        o_flags  = i_req.flags;
        unique case (i_req.cmd)
            CMD_ADD, CMD_ADC: begin
                r8      = sum8[7:0];
                o_flags = '{z: 1'b0, n: 1'b0, h: sum4[4], c: sum8[8]};
            end
            CMD_SUB, CMD_SBC: begin
                r8      = dif8[7:0];
                o_flags = '{z: 1'b0, n: 1'b1, h: dif4[4], c: dif8[8]};
            end
            CMD_AND: begin
                r8      = a & b;
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b1, c: 1'b0};
            end
            CMD_OR: begin
                r8      = a | b;
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_XOR: begin
                r8      = a ^ b;
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_INC: begin
                r8      = a + 8'd1;
                o_flags = '{z: 1'b0, n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
            end
            CMD_DEC: begin
                r8      = a - 8'd1;
                o_flags = '{z: 1'b0, n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
            end
            CMD_RLC: begin
                r8      = {a[6:0], a[7]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            CMD_RL: begin
                r8      = {a[6:0], cin};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            CMD_RRC: begin
                r8      = {a[0], a[7:1]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            CMD_RR: begin
                r8      = {cin, a[7:1]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            CMD_SLA: begin
                r8      = {a[6:0], 1'b0};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            CMD_SRA: begin
                r8      = {a[7], a[7:1]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            CMD_SRL: begin
                r8      = {1'b0, a[7:1]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            CMD_SWAP: begin
                r8      = {a[3:0], a[7:4]};
                o_flags = '{z: 1'b0, n: 1'b0, h: 1'b0, c: 1'b0};
            end
            CMD_BIT: begin
                r8      = a;
                o_flags = '{z: ~a[i_req.idx], n: 1'b0, h: 1'b1, c: cin};
            end
            CMD_SET: begin
                r8 = a | mask;
            end
            CMD_RES: begin
                r8 = a & ~mask;
            end
            default: begin
                r8 = 8'd0;
            end
        endcase

        // The zero flag of most 8-bit operations comes from the result byte.
        z8 = (r8 == 8'd0);
        unique case (i_req.cmd)
            CMD_BIT, CMD_SET, CMD_RES: begin
                o_result = {8'd0, r8};
            end
            CMD_ADD16: begin
                o_result = sum16[15:0];
                o_flags  = '{z: i_req.flags.z, n: 1'b0, h: sum12[12], c: sum16[16]};
            end
            CMD_ADDOFS: begin
                o_result = ofs;
                o_flags  = '{z: 1'b0, n: 1'b0, h: sum4[4], c: sum8[8]};
            end
            default: begin
                o_result = {8'd0, r8};
                if (i_req.cmd <= CMD_SWAP) begin
                    o_flags.z = z8;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/cpu_alu_with_flags.sv
// 8-bit CPU ALU with Z, N, H and C flags, plus a 16-bit add and a signed
// offset add. A beat is taken on every clock edge at which start is high;
// busy is always low, so one operation can be issued in every cycle. The
// operands are captured in an input register, the ALU works in one pass of
// combinational logic, and the result register presents the value and the
// new flags with o_done high for exactly one cycle. That cycle starts at the
// first clock edge after the beat was taken, and the result is taken at the
// edge that ends it. The receiver cannot stall the result, and none is
// needed: with one operation per cycle in and out, nothing ever backs up.
// Unused command codes return zero with the flags passed through.
`default_nettype none

module cpu_alu_with_flags (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [4:0]  i_command,
    input  logic [15:0] i_operand_a,
    input  logic [15:0] i_operand_b,
    input  logic [2:0]  i_bit_index,
    input  logic [3:0]  i_flags_in,
    output logic        o_done,
    output logic [15:0] o_result_value,
    output logic [3:0]  o_flags_out
);
    import cpualu_pkg::*;

    logic        r_in_valid;
    t_alu_req    r_req;
    logic        r_out_valid;
    logic [15:0] r_result;
    t_flags      r_flags;
    logic [15:0] alu_result;
    t_flags      alu_flags;

    // The pipeline never stalls.
    assign busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        if (start & ~busy) begin
            r_req.cmd   <= t_cmd'(i_command);
            r_req.a     <= i_operand_a;
            r_req.b     <= i_operand_b;
            r_req.idx   <= i_bit_index;
            r_req.flags <= t_flags'(i_flags_in);
        end
    end

    cpualu_core u_core (
        .i_req    (r_req),
        .o_result (alu_result),
        .o_flags  (alu_flags)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid) begin
            r_result <= alu_result;
            r_flags  <= alu_flags;
        end
    end

    assign o_done         = r_out_valid;
    assign o_result_value = r_result;
    assign o_flags_out    = r_flags;

`ifndef SYNTHESIS
    // A result follows every captured beat in the next cycle.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done == $past(r_in_valid))
        else $error("result strobe does not follow the input register");

    // Set and reset of a bit leave all flags as they came in.
    a_setres_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && (r_req.cmd == CMD_SET || r_req.cmd == CMD_RES)
        |=> o_flags_out == $past(r_req.flags))
        else $error("set or reset changed the flags");

    // Eight-bit operations keep the high byte of the result clear.
    a_high_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_req.cmd != CMD_ADD16 && r_req.cmd != CMD_ADDOFS
        |=> o_result_value[15:8] == 8'd0)
        else $error("high byte set by an eight-bit operation");
`endif

endmodule

`default_nettype wire
